FILE: rtl/core/aes_bcm_pkg.sv
`timescale 1ns / 1ps
package aes_bcm_pkg;

   localparam int DEF_MAX_ROUNDS = 14;

   // register indexes on the csr port
   localparam logic [2:0] REG_KEY_LENGTH = 3'd0;
   localparam logic [2:0] REG_CHAIN_MODE = 3'd1;
   localparam logic [2:0] REG_DIRECTION  = 3'd2;
   localparam logic [2:0] REG_KEY_WORD_0 = 3'd3;
   localparam logic [2:0] REG_KEY_WORD_1 = 3'd4;
   localparam logic [2:0] REG_KEY_WORD_2 = 3'd5;
   localparam logic [2:0] REG_KEY_WORD_3 = 3'd6;

   localparam logic [1:0] KEY_128 = 2'd0;
   localparam logic [1:0] KEY_192 = 2'd1;
   localparam logic [1:0] KEY_256 = 2'd2;
   localparam logic [1:0] KEY_RSVD = 2'd3;

   localparam logic [1:0] MODE_ECB = 2'd0;
   localparam logic [1:0] MODE_CBC = 2'd1;
   localparam logic [1:0] MODE_CTR = 2'd2;

   localparam int ROUNDS_128 = 10;
   localparam int ROUNDS_192 = 12;
   localparam int ROUNDS_256 = 14;

   localparam logic [7:0] RCON_INIT = 8'h01;
   localparam logic [4:0] FULL_BLOCK = 5'd16;

   localparam logic [2047:0] SBOX_TBL = {
      128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

   localparam logic [2047:0] INV_SBOX_TBL = {
      128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
      128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
      128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
      128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
      128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
      128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
      128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
      128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

   function automatic logic [7:0] sbox(input logic [7:0] b);
      logic [10:0] idx;
      idx = 11'd2047 - {b, 3'b000};
      return SBOX_TBL[idx -: 8];
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] b);
      logic [10:0] idx;
      idx = 11'd2047 - {b, 3'b000};
      return INV_SBOX_TBL[idx -: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   // byte 0 sits in the top bits
   function automatic logic [127:0] sub_bytes(input logic [127:0] s);
      logic [127:0] r;
      for (int i = 0; i < 16; i++) r[127-8*i -: 8] = sbox(s[127-8*i -: 8]);
      return r;
   endfunction

   function automatic logic [127:0] inv_sub_bytes(input logic [127:0] s);
      logic [127:0] r;
      for (int i = 0; i < 16; i++) r[127-8*i -: 8] = inv_sbox(s[127-8*i -: 8]);
      return r;
   endfunction

   function automatic logic [127:0] shift_rows(input logic [127:0] s);
      logic [127:0] r;
      for (int c = 0; c < 4; c++)
         for (int w = 0; w < 4; w++)
            r[127-8*(w+4*c) -: 8] = s[127-8*(w+4*((c+w)%4)) -: 8];
      return r;
   endfunction

   function automatic logic [127:0] inv_shift_rows(input logic [127:0] s);
      logic [127:0] r;
      for (int c = 0; c < 4; c++)
         for (int w = 0; w < 4; w++)
            r[127-8*(w+4*((c+w)%4)) -: 8] = s[127-8*(w+4*c) -: 8];
      return r;
   endfunction

   function automatic logic [127:0] mix_columns(input logic [127:0] s);
      logic [127:0] r;
      logic [7:0] a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127-32*c -: 8];
         a1 = s[119-32*c -: 8];
         a2 = s[111-32*c -: 8];
         a3 = s[103-32*c -: 8];
         r[127-32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         r[119-32*c -: 8] = xtime(a1) ^ xtime(a2) ^ a2 ^ a3 ^ a0;
         r[111-32*c -: 8] = xtime(a2) ^ xtime(a3) ^ a3 ^ a0 ^ a1;
         r[103-32*c -: 8] = xtime(a3) ^ xtime(a0) ^ a0 ^ a1 ^ a2;
      end
      return r;
   endfunction

   function automatic logic [7:0] mul_e(input logic [7:0] a);
      logic [7:0] x2, x4, x8;
      x2 = xtime(a); x4 = xtime(x2); x8 = xtime(x4);
      return x8 ^ x4 ^ x2;
   endfunction

   function automatic logic [7:0] mul_b(input logic [7:0] a);
      logic [7:0] x2, x4, x8;
      x2 = xtime(a); x4 = xtime(x2); x8 = xtime(x4);
      return x8 ^ x2 ^ a;
   endfunction

   function automatic logic [7:0] mul_d(input logic [7:0] a);
      logic [7:0] x2, x4, x8;
      x2 = xtime(a); x4 = xtime(x2); x8 = xtime(x4);
      return x8 ^ x4 ^ a;
   endfunction

   function automatic logic [7:0] mul_9(input logic [7:0] a);
      logic [7:0] x2, x4, x8;
      x2 = xtime(a); x4 = xtime(x2); x8 = xtime(x4);
      return x8 ^ a;
   endfunction

   function automatic logic [127:0] inv_mix_columns(input logic [127:0] s);
      logic [127:0] r;
      logic [7:0] a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127-32*c -: 8];
         a1 = s[119-32*c -: 8];
         a2 = s[111-32*c -: 8];
         a3 = s[103-32*c -: 8];
         r[127-32*c -: 8] = mul_e(a0) ^ mul_b(a1) ^ mul_d(a2) ^ mul_9(a3);
         r[119-32*c -: 8] = mul_e(a1) ^ mul_b(a2) ^ mul_d(a3) ^ mul_9(a0);
         r[111-32*c -: 8] = mul_e(a2) ^ mul_b(a3) ^ mul_d(a0) ^ mul_9(a1);
         r[103-32*c -: 8] = mul_e(a3) ^ mul_b(a0) ^ mul_d(a1) ^ mul_9(a2);
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/aes_block_cipher_modes.sv
`timescale 1ns / 1ps
// AES-128/192/256 in ECB, CBC or CTR mode, one 16-byte block per request. A write to
// key_length or any key word starts key expansion: one key word a cycle, 4*(Nr+1)
// words in all, then the decryption key schedule is built; requests are held off
// until it ends. A request then passes through the single shared round unit
// (Nr = 10, 12 or 14): a load step, Nr+1 round steps (whitening plus one round a
// cycle, keys read from the round key memory one round ahead) and a step of chaining
// and counter update into the result register. A new request is taken once the block
// is in the result register, even while that result still waits to be taken.
module aes_block_cipher_modes #(
   parameter int MAX_ROUNDS = aes_bcm_pkg::DEF_MAX_ROUNDS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // data_hi, data_lo, iv_hi, iv_lo, valid_bytes, zero pad
   input  logic [263:0] req_tdata,
   // start_req
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_hi, out_lo, next_chain_hi, next_chain_lo
   output logic [255:0] rsp_tdata,
   input  logic         csr_wen,
   input  logic [2:0]   csr_addr,
   input  logic [63:0]  csr_wdata
);
   import aes_bcm_pkg::*;

   localparam int AW = $clog2(MAX_ROUNDS + 1);
   localparam int CW = $clog2(MAX_ROUNDS + 2);
   localparam int WW = $clog2(4 * (MAX_ROUNDS + 1));

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RUN  = 3'd1;
   localparam logic [2:0] ST_DONE = 3'd2;
   localparam logic [2:0] ST_KEXP = 3'd3;
   localparam logic [2:0] ST_KINV = 3'd4;

   logic [2:0]   state_ff, state_in;
   logic [1:0]   key_len_ff, key_len_in;
   logic [1:0]   mode_ff, mode_in;
   logic         dir_ff, dir_in;
   logic [63:0]  kw_ff [4];
   logic [127:0] chain_ff, chain_in;
   logic [127:0] blk_ff, blk_in;
   logic [127:0] data_ff, data_in;
   logic [4:0]   vb_ff, vb_in;
   logic [CW-1:0] rnd_ff, rnd_in;
   logic [WW-1:0] widx_ff, widx_in;
   logic [2:0]   kmod_ff, kmod_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic [31:0]  win_ff [8];
   logic         rsp_valid_ff, rsp_valid_in;
   logic [255:0] rsp_data_ff, rsp_data_in;

   logic [127:0] enc_mem [0:MAX_ROUNDS];
   logic [127:0] dec_mem [0:MAX_ROUNDS];
   logic [127:0] enc_rd_ff, dec_rd_ff;

   logic [CW-1:0] nr;
   logic [3:0]    nk;
   logic          is_ctr, is_cbc, do_dec, key_wr, accept, rsp_free;
   logic [AW-1:0] enc_addr, dec_addr;
   logic [127:0]  rkey, round_out, iv, chain_sel, post_out, post_chain, mask;
   logic [31:0]   key_word, exp_word, t_word, w_old;
   logic          enc_we, dec_we;
   logic [AW-1:0] enc_waddr, dec_waddr;
   logic [127:0]  enc_wdata, dec_wdata;
   logic [CW-1:0] inv_row;
   logic [4:0]    nbytes;

   assign is_ctr = (mode_ff == MODE_CTR);
   assign is_cbc = (mode_ff == MODE_CBC);
   assign do_dec = !is_ctr && dir_ff;
   assign key_wr = csr_wen && (csr_addr == REG_KEY_LENGTH || csr_addr == REG_KEY_WORD_0 ||
                   csr_addr == REG_KEY_WORD_1 || csr_addr == REG_KEY_WORD_2 ||
                   csr_addr == REG_KEY_WORD_3);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   always_comb begin
      int r;
      case (key_len_ff)
         KEY_128: begin r = ROUNDS_128; nk = 4'd4; end
         KEY_192: begin r = ROUNDS_192; nk = 4'd6; end
         default: begin r = ROUNDS_256; nk = 4'd8; end
      endcase
      if (r > MAX_ROUNDS) r = MAX_ROUNDS;
      nr = CW'(r);
   end

   // key expansion: one word per cycle, window keeps the last eight words
   always_comb begin
      key_word = widx_ff[0] ? kw_ff[widx_ff[2:1]][31:0] : kw_ff[widx_ff[2:1]][63:32];
      case (nk)
         4'd4:    w_old = win_ff[4];
         4'd6:    w_old = win_ff[2];
         default: w_old = win_ff[0];
      endcase
      t_word = win_ff[7];
      if (kmod_ff == 3'd0)
         t_word = sub_word({t_word[23:0], t_word[31:24]}) ^ {rcon_ff, 24'd0};
      else if (nk == 4'd8 && kmod_ff == 3'd4)
         t_word = sub_word(t_word);
      exp_word = (widx_ff < WW'(nk)) ? key_word : (w_old ^ t_word);
   end

   assign inv_row = rnd_ff - CW'(1);
   always_comb begin
      enc_addr = AW'(rnd_ff + CW'(1));
      if (state_ff == ST_KINV) enc_addr = AW'(nr - rnd_ff);
      else if (state_ff == ST_IDLE) enc_addr = '0;
      dec_addr = (state_ff == ST_IDLE) ? AW'(0) : AW'(rnd_ff + CW'(1));
      enc_we = (state_ff == ST_KEXP) && (widx_ff[1:0] == 2'd3);
      enc_waddr = AW'(widx_ff >> 2);
      enc_wdata = {win_ff[5], win_ff[6], win_ff[7], exp_word};
      dec_we = (state_ff == ST_KINV) && (rnd_ff != '0);
      dec_waddr = AW'(inv_row);
      dec_wdata = (inv_row != '0 && inv_row != nr) ? inv_mix_columns(enc_rd_ff) : enc_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (enc_we) enc_mem[enc_waddr] <= enc_wdata;
      if (dec_we) dec_mem[dec_waddr] <= dec_wdata;
      enc_rd_ff <= enc_mem[enc_addr];
      dec_rd_ff <= dec_mem[dec_addr];
   end

   // shared round unit
   always_comb begin
      rkey = do_dec ? dec_rd_ff : enc_rd_ff;
      if (rnd_ff == '0) begin
         round_out = blk_ff ^ rkey;
      end else if (do_dec) begin
         round_out = inv_shift_rows(inv_sub_bytes(blk_ff));
         if (rnd_ff != nr) round_out = inv_mix_columns(round_out);
         round_out = round_out ^ rkey;
      end else begin
         round_out = shift_rows(sub_bytes(blk_ff));
         if (rnd_ff != nr) round_out = mix_columns(round_out);
         round_out = round_out ^ rkey;
      end
   end

   always_comb begin
      iv = req_tdata[255:128];
      chain_sel = req_tuser ? {iv[63:0], iv[127:64]} : chain_ff;
      nbytes = (vb_ff > FULL_BLOCK) ? FULL_BLOCK : vb_ff;
      for (int i = 0; i < 16; i++) mask[127-8*i -: 8] = (5'(i) < nbytes) ? 8'hff : 8'h00;
      post_out = blk_ff;
      post_chain = chain_ff;
      if (is_ctr) begin
         post_out = (blk_ff ^ data_ff) & mask;
         if (nbytes == FULL_BLOCK) post_chain = chain_ff + 128'd1;
      end else if (is_cbc) begin
         if (dir_ff) begin
            post_out = blk_ff ^ chain_ff;
            post_chain = data_ff;
         end else begin
            post_chain = blk_ff;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      key_len_in = key_len_ff;
      mode_in = mode_ff;
      dir_in = dir_ff;
      chain_in = chain_ff;
      blk_in = blk_ff;
      data_in = data_ff;
      vb_in = vb_ff;
      rnd_in = rnd_ff;
      widx_in = widx_ff;
      kmod_in = kmod_ff;
      rcon_in = rcon_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      if (csr_wen) begin
         case (csr_addr)
            REG_KEY_LENGTH: key_len_in = (csr_wdata[1:0] == KEY_RSVD) ? KEY_256 : csr_wdata[1:0];
            REG_CHAIN_MODE: mode_in = csr_wdata[1:0];
            REG_DIRECTION:  dir_in = csr_wdata[0];
            default: ;
         endcase
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               data_in = {req_tdata[63:0], req_tdata[127:64]};
               vb_in = req_tdata[260:256];
               chain_in = chain_sel;
               if (mode_ff == MODE_CTR) blk_in = chain_sel;
               else if (mode_ff == MODE_CBC && !dir_ff) blk_in = data_in ^ chain_sel;
               else blk_in = data_in;
               rnd_in = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            blk_in = round_out;
            rnd_in = rnd_ff + CW'(1);
            if (rnd_ff == nr) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {post_chain[63:0], post_chain[127:64],
                              post_out[63:0], post_out[127:64]};
               chain_in = post_chain;
               state_in = ST_IDLE;
            end
         end
         ST_KEXP: begin
            widx_in = widx_ff + WW'(1);
            kmod_in = (kmod_ff == 3'(nk - 4'd1)) ? 3'd0 : kmod_ff + 3'd1;
            if (widx_ff >= WW'(nk) && kmod_ff == 3'd0) rcon_in = xtime(rcon_ff);
            if (widx_ff == WW'(4 * (nr + CW'(1)) - 1)) begin
               rnd_in = '0;
               state_in = ST_KINV;
            end
         end
         ST_KINV: begin
            rnd_in = rnd_ff + CW'(1);
            if (rnd_ff == nr + CW'(1)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (key_wr) begin
         widx_in = '0;
         kmod_in = '0;
         rcon_in = RCON_INIT;
         state_in = ST_KEXP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         key_len_ff <= KEY_128;
         mode_ff <= MODE_ECB;
         dir_ff <= 1'b0;
         for (int i = 0; i < 4; i++) kw_ff[i] <= '0;
         chain_ff <= '0;
         rnd_ff <= '0;
         widx_ff <= '0;
         kmod_ff <= '0;
         rcon_ff <= RCON_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         key_len_ff <= key_len_in;
         mode_ff <= mode_in;
         dir_ff <= dir_in;
         if (csr_wen && csr_addr == REG_KEY_WORD_0) kw_ff[0] <= csr_wdata;
         if (csr_wen && csr_addr == REG_KEY_WORD_1) kw_ff[1] <= csr_wdata;
         if (csr_wen && csr_addr == REG_KEY_WORD_2) kw_ff[2] <= csr_wdata;
         if (csr_wen && csr_addr == REG_KEY_WORD_3) kw_ff[3] <= csr_wdata;
         chain_ff <= chain_in;
         rnd_ff <= rnd_in;
         widx_ff <= widx_in;
         kmod_ff <= kmod_in;
         rcon_ff <= rcon_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      data_ff <= data_in;
      vb_ff <= vb_in;
      rsp_data_ff <= rsp_data_in;
      if (state_ff == ST_KEXP) begin
         for (int i = 0; i < 7; i++) win_ff[i] <= win_ff[i+1];
         win_ff[7] <= exp_word;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept && !key_wr |=> state_ff == ST_RUN && rnd_ff == '0)
      else $error("request did not start the round unit");

   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> rnd_ff <= nr)
      else $error("round counter overran");

   a_chain_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN && $past(state_ff) == ST_RUN |-> $stable(chain_ff))
      else $error("chain register moved mid block");

   a_key_restart: assert property (@(posedge clock) disable iff (reset)
      key_wr |=> state_ff == ST_KEXP && widx_ff == '0)
      else $error("key write did not restart expansion");

endmodule
